@@ hw/rtl/ddso_pkg.sv @@
// ----------------------------------------------------------------------------
// ddso_pkg
// Shared types, constants and the CORDIC arctangent table for the
// differential-drive step odometry block.
// ----------------------------------------------------------------------------
package ddso_pkg;

  // Field widths
  localparam int unsigned CFG_W     = 24;   // configuration register width
  localparam int unsigned CFG_IDX_W = 2;    // configuration index width
  localparam int unsigned POS_W     = 48;   // position accumulators
  localparam int unsigned ANG_W     = 32;   // binary angle
  localparam int unsigned CRD_W     = 32;   // CORDIC x/y/z datapath
  localparam int unsigned DIST_W    = CFG_W + 1;  // distance for one or two wheels
  localparam int unsigned PROD_W    = CRD_W + DIST_W + 1;
  localparam int unsigned ITER_W    = 5;    // iteration index, up to 32 iterations

  // Default iteration count
  localparam int unsigned CORDIC_ITERATIONS_DEF = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_ANGLE    = 2'd1;

  // CORDIC start value: gain compensation in Q30
  localparam logic signed [CRD_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_ACC_Y,
    ST_DONE
  } ddso_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              load;      // item accepted: latch step flags, set up rotation
    logic              rotate;    // one CORDIC micro-rotation
    logic [ITER_W-1:0] iter;      // micro-rotation index
    logic              mul_en;    // register one displacement product
    logic              mul_sel_y; // product uses sine instead of cosine
    logic              acc_en;    // add rounded product into a position
    logic              acc_sel_y; // accumulate into y instead of x
    logic              out_load;  // copy pose into the output register
  } ddso_cmd_t;

  // atan(2^-i) in units of 2^-32 turn, rounded to nearest
  function automatic logic [ANG_W-1:0] atan_turns(input logic [ITER_W-1:0] i);
    logic [ANG_W-1:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/ddso_ctrl.sv @@
// ----------------------------------------------------------------------------
// ddso_ctrl
// Sequencer: accepts an item; for an item with a step it steps the CORDIC
// iterations and runs the two displacement products and accumulations;
// then it hands the pose to the output register.
// ----------------------------------------------------------------------------
module ddso_ctrl #(
  parameter int unsigned ITERATIONS = ddso_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_moved,
  output logic                out_valid,
  input  logic                out_ready,
  output ddso_pkg::ddso_cmd_t cmd
);
  import ddso_pkg::*;

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ITERATIONS - 1);

  ddso_state_t       state, state_next;
  logic [ITER_W-1:0] iter;
  logic              accept;
  logic              out_free;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = in_moved ? ST_ROTATE : ST_DONE;
      end
      ST_ROTATE: begin
        if (iter == LAST_ITER) state_next = ST_MUL_X;
      end
      ST_MUL_X: state_next = ST_MUL_Y;
      ST_MUL_Y: state_next = ST_ACC_Y;
      ST_ACC_Y: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.iter      = iter;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ROTATE: cmd.rotate = 1'b1;
      ST_MUL_X:  cmd.mul_en = 1'b1;
      ST_MUL_Y: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_sel_y = 1'b1;
        cmd.acc_en    = 1'b1;
      end
      ST_ACC_Y: begin
        cmd.acc_en    = 1'b1;
        cmd.acc_sel_y = 1'b1;
      end
      ST_DONE: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // State, iteration counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      iter      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept || state != ST_ROTATE) iter <= '0;
      else iter <= iter + 1'b1;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

@@ hw/rtl/ddso_dp.sv @@
// ----------------------------------------------------------------------------
// ddso_dp
// Datapath: configuration registers, pose state, iterative CORDIC rotator,
// shared displacement multiplier, saturating accumulators and the output
// register.
// ----------------------------------------------------------------------------
module ddso_dp (
  input  logic                                 clk,
  input  logic                                 cfg_we,
  input  logic [ddso_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ddso_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 rst,
  input  logic                                 left_step,
  input  logic                                 right_step,
  input  ddso_pkg::ddso_cmd_t                  cmd,
  output logic signed [ddso_pkg::POS_W-1:0]    x_pos,
  output logic signed [ddso_pkg::POS_W-1:0]    y_pos,
  output logic [ddso_pkg::ANG_W-1:0]           heading,
  output logic                                 moved
);
  import ddso_pkg::*;

  localparam int unsigned DISP_W = PROD_W - 31;
  localparam int unsigned SUM_W  = POS_W + 1;

  logic [CFG_W-1:0]              step_distance;
  logic [CFG_W-1:0]              step_angle;
  logic signed [POS_W-1:0]       pose_x;
  logic signed [POS_W-1:0]       pose_y;
  logic [ANG_W-1:0]              pose_heading;

  logic [DIST_W-1:0]             d2;
  logic                          flip;
  logic                          item_moved;
  logic signed [CRD_W-1:0]       cx, cy, cz;
  logic signed [PROD_W-1:0]      prod;

  logic [ANG_W-1:0]              half, mid, nheading, folded;
  logic                          mid_flip;
  logic signed [CRD_W-1:0]       xs, ys, atan_s;
  logic signed [CRD_W-1:0]       mul_a;
  logic signed [PROD_W-1:0]      rnd;
  logic signed [DISP_W-1:0]      disp;
  logic signed [SUM_W-1:0]       sum;
  logic signed [POS_W-1:0]       sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step_distance <= '0;
      step_angle    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_DISTANCE: step_distance <= cfg_data;
        REG_STEP_ANGLE:    step_angle    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Mid-motion heading and new heading for a single-wheel step
  always_comb begin
    half     = ANG_W'(step_angle >> 1);
    mid      = pose_heading;
    nheading = pose_heading;
    if (right_step && !left_step) begin
      mid      = pose_heading + half;
      nheading = pose_heading + ANG_W'(step_angle);
    end else if (left_step && !right_step) begin
      mid      = pose_heading - half;
      nheading = pose_heading - ANG_W'(step_angle);
    end
    // fold [1/4, 3/4) turn by half a turn
    mid_flip = mid[ANG_W-1] ^ mid[ANG_W-2];
    folded   = mid_flip ? {~mid[ANG_W-1], mid[ANG_W-2:0]} : mid;
  end

  // CORDIC micro-rotation terms
  assign xs     = cx >>> cmd.iter;
  assign ys     = cy >>> cmd.iter;
  assign atan_s = signed'(atan_turns(cmd.iter));

  // Item setup and rotation
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_moved <= left_step || right_step;
      d2   <= (left_step && right_step) ? {step_distance, 1'b0} : {1'b0, step_distance};
      flip <= mid_flip;
      cx   <= CORDIC_GAIN_Q30;
      cy   <= '0;
      cz   <= signed'(folded);
    end else if (cmd.rotate) begin
      if (!cz[CRD_W-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_s;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_s;
      end
    end
  end

  // Shared displacement multiplier
  always_comb begin
    mul_a = cmd.mul_sel_y ? cy : cx;
    if (flip) mul_a = -mul_a;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= PROD_W'(mul_a) * PROD_W'(signed'({1'b0, d2}));
  end

  // Round to nearest and add with saturation
  always_comb begin
    rnd  = prod + (PROD_W'(1) <<< 30);
    disp = DISP_W'(rnd >>> 31);
    sum  = (cmd.acc_sel_y ? SUM_W'(pose_y) : SUM_W'(pose_x)) + SUM_W'(disp);
    if (sum[SUM_W-1] != sum[SUM_W-2])
      sat = sum[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    else
      sat = sum[POS_W-1:0];
  end

  // Pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x       <= '0;
      pose_y       <= '0;
      pose_heading <= '0;
    end else begin
      if (cmd.load) pose_heading <= nheading;
      if (cmd.acc_en) begin
        if (cmd.acc_sel_y) pose_y <= sat;
        else pose_x <= sat;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      x_pos   <= pose_x;
      y_pos   <= pose_y;
      heading <= pose_heading;
      moved   <= item_moved;
    end
  end

endmodule

@@ hw/rtl/differential_drive_step_odometry.sv @@
// ----------------------------------------------------------------------------
// differential_drive_step_odometry
// A stepping item goes from acceptance through the CORDIC rotation and the x
// and y products and accumulations to the output register; one with no step
// goes straight there. A new item is accepted only once the last one has
// left the single iterative CORDIC rotator and its result has been registered.
// Reset (synchronous): pose and both configuration registers clear to zero.
// ----------------------------------------------------------------------------
module differential_drive_step_odometry #(
  parameter int unsigned CORDIC_ITERATIONS = ddso_pkg::CORDIC_ITERATIONS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [ddso_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ddso_pkg::CFG_W-1:0]       cfg_data,
  // input items
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // [0] left_step, [1] right_step
  // result items
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [127:0]                     m_tdata,  // x_pos[47:0], y_pos, heading
  output logic                             m_tuser   // [0] moved
);
  import ddso_pkg::*;

  ddso_cmd_t               cmd;
  logic signed [POS_W-1:0] x_pos, y_pos;
  logic [ANG_W-1:0]        heading;
  logic                    moved;

  // Sequencer
  ddso_ctrl #(
    .ITERATIONS (CORDIC_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_moved  (s_tdata[0] | s_tdata[1]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  // Datapath
  ddso_dp u_dp (
    .clk        (clk),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rst        (rst),
    .left_step  (s_tdata[0]),
    .right_step (s_tdata[1]),
    .cmd        (cmd),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .heading    (heading),
    .moved      (moved)
  );

  // Result packing
  assign m_tdata = {heading, y_pos, x_pos};
  assign m_tuser = moved;

endmodule

@@ sim/tb_differential_drive_step_odometry.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_differential_drive_step_odometry
// Self-checking bench for the step odometry block. A queue-fed driver sends
// wheel step items. A behavioral pose tracker computes the expected
// position and heading, with its own CORDIC. A monitor compares every result
// item field by field. Configuration changes only while the block is idle.
// ----------------------------------------------------------------------------
module tb_differential_drive_step_odometry;

  localparam int unsigned CORDIC_ITER = ddso_pkg::CORDIC_ITERATIONS_DEF;
  localparam longint      CORDIC_START = 64'sd652032874;  // K * 2^30
  localparam longint      POS_HI = 64'sd140737488355327;
  localparam longint      POS_LO = -64'sd140737488355328;

  // indexes past the register file: writes must be ignored
  localparam logic [ddso_pkg::CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [ddso_pkg::CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic right;
    logic left;
  } step_item_t;

  typedef struct packed {
    logic [47:0] x;
    logic [47:0] y;
    logic [31:0] heading;
    logic        moved;
  } pose_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_we    = 1'b0;
  logic [ddso_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ddso_pkg::CFG_W-1:0]     cfg_data  = '0;

  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata  = '0;   // [0] left_step, [1] right_step
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;         // [47:0] x_pos, [95:48] y_pos, [127:96] heading
  logic         m_tuser;         // [0] moved

  differential_drive_step_odometry #(
    .CORDIC_ITERATIONS(CORDIC_ITER)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // stimulus and scoreboard storage
  step_item_t pending_steps[$];
  pose_t      expected_poses[$];
  step_item_t presented;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatch_count = 0;
  int items_sent = 0;
  int poses_checked = 0;
  int moves_checked = 0;
  int reg_writes = 0;

  // tracker state
  logic [23:0] trk_distance = '0;
  logic [23:0] trk_angle    = '0;
  longint      trk_x = 0;
  longint      trk_y = 0;
  logic [31:0] trk_heading = '0;

  // atan(2^-i) in 2^-32 turn, rounded to nearest
  function automatic longint micro_angle(input int i);
    case (i)
      0:  return 536870912;
      1:  return 316933406;
      2:  return 167458907;
      3:  return 85004756;
      4:  return 42667331;
      5:  return 21354465;
      6:  return 10679838;
      7:  return 5340245;
      8:  return 2670163;
      9:  return 1335087;
      10: return 667544;
      11: return 333772;
      12: return 166886;
      13: return 83443;
      14: return 41722;
      15: return 20861;
      16: return 10430;
      17: return 5215;
      18: return 2608;
      19: return 1304;
      20: return 652;
      21: return 326;
      22: return 163;
      23: return 81;
      24: return 41;
      25: return 20;
      26: return 10;
      27: return 5;
      28: return 3;
      29: return 1;
      30: return 1;
      default: return 0;
    endcase
  endfunction

  // cosine and sine of a binary angle in Q30
  function automatic void rotate_unit(input logic [31:0] ang, output longint c,
                                      output longint s);
    logic [31:0] a;
    logic [31:0] probe;
    logic        flip;
    longint      x, y, z, xs, ys;
    a = ang;
    probe = ang + 32'h4000_0000;
    flip = probe[31];
    // left half-plane folds onto the right one
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = CORDIC_START;
    y = 0;
    for (int i = 0; i < CORDIC_ITER && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - micro_angle(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + micro_angle(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint clamp_pos(input longint v);
    if (v > POS_HI) return POS_HI;
    if (v < POS_LO) return POS_LO;
    return v;
  endfunction

  // advance the tracked pose by one item and return the expected result
  function automatic pose_t advance_pose(input step_item_t it);
    pose_t       res;
    logic [31:0] mid;
    logic [31:0] next_heading;
    longint      d2, c, s;
    if (it.left || it.right) begin
      mid = trk_heading;
      next_heading = trk_heading;
      if (it.left && it.right) begin
        d2 = 2 * longint'(trk_distance);
      end else begin
        d2 = longint'(trk_distance);
        if (it.right) begin
          mid = mid + {9'd0, trk_angle[23:1]};
          next_heading = next_heading + {8'd0, trk_angle};
        end else begin
          mid = mid - {9'd0, trk_angle[23:1]};
          next_heading = next_heading - {8'd0, trk_angle};
        end
      end
      rotate_unit(mid, c, s);
      trk_x = clamp_pos(trk_x + ((c * d2 + (64'sd1 <<< 30)) >>> 31));
      trk_y = clamp_pos(trk_y + ((s * d2 + (64'sd1 <<< 30)) >>> 31));
      trk_heading = next_heading;
    end
    res.x = trk_x[47:0];
    res.y = trk_y[47:0];
    res.heading = trk_heading;
    res.moved = it.left | it.right;
    return res;
  endfunction

  // driver: presents queued step items, idles at random
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_poses.push_back(advance_pose(presented));
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_steps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          presented = pending_steps.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= {6'd0, presented};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // monitor: checks result items against the oldest expectation
  always @(posedge clk) begin
    pose_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_poses.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h / %b",
                   $time, m_tdata, m_tuser);
          mismatch_count++;
        end else begin
          want = expected_poses.pop_front();
          check_field("x_pos", {16'd0, want.x}, {16'd0, m_tdata[47:0]});
          check_field("y_pos", {16'd0, want.y}, {16'd0, m_tdata[95:48]});
          check_field("heading", {32'd0, want.heading}, {32'd0, m_tdata[127:96]});
          check_field("moved", {63'd0, want.moved}, {63'd0, m_tuser});
          poses_checked++;
          if (want.moved) moves_checked++;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // register write; the tracker follows the same decode
  task automatic write_reg(input logic [ddso_pkg::CFG_IDX_W-1:0] idx,
                           input logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ddso_pkg::REG_STEP_DISTANCE: trk_distance = val;
      ddso_pkg::REG_STEP_ANGLE:    trk_angle = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
  endtask

  task automatic queue_step(input logic l, input logic r);
    step_item_t it;
    it.left = l;
    it.right = r;
    pending_steps.push_back(it);
  endtask

  // weighted mix of no step / left / right / both
  task automatic queue_random(input int n, input int w_none, input int w_left,
                              input int w_right, input int w_both);
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(w_none + w_left + w_right + w_both - 1);
      if (pick < w_none) queue_step(1'b0, 1'b0);
      else if (pick < w_none + w_left) queue_step(1'b1, 1'b0);
      else if (pick < w_none + w_left + w_right) queue_step(1'b0, 1'b1);
      else queue_step(1'b1, 1'b1);
    end
  endtask

  // wait until every queued item went through and every result came back
  task automatic drain_pipeline();
    while (pending_steps.size() != 0 || s_tvalid || expected_poses.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 84;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers at reset value: nothing moves even when wheels step
    queue_step(1'b0, 1'b0);
    queue_step(1'b1, 1'b0);
    queue_step(1'b0, 1'b1);
    queue_step(1'b1, 1'b1);
    drain_pipeline();

    // largest distance and angle; writes past the register file are ignored
    write_reg(ddso_pkg::REG_STEP_DISTANCE, 24'hFF_FFFF);
    write_reg(ddso_pkg::REG_STEP_ANGLE, 24'hFF_FFFF);
    write_reg(REG_UNUSED_2, 24'($urandom));
    write_reg(REG_UNUSED_3, 24'($urandom));
    queue_step(1'b0, 1'b0);
    queue_step(1'b1, 1'b0);
    queue_step(1'b1, 1'b0);
    queue_step(1'b0, 1'b1);
    queue_step(1'b1, 1'b1);
    queue_step(1'b0, 1'b1);
    queue_step(1'b0, 1'b1);
    queue_step(1'b0, 1'b0);
    queue_step(1'b1, 1'b1);
    drain_pipeline();

    // smallest nonzero values: rounding of halves and odd angles
    write_reg(ddso_pkg::REG_STEP_DISTANCE, 24'd1);
    write_reg(ddso_pkg::REG_STEP_ANGLE, 24'd1);
    queue_step(1'b1, 1'b0);
    queue_step(1'b0, 1'b1);
    queue_step(1'b1, 1'b1);
    queue_step(1'b0, 1'b0);
    drain_pipeline();

    // zero distance with full angle: heading turns, position stays
    write_reg(ddso_pkg::REG_STEP_DISTANCE, 24'd0);
    write_reg(ddso_pkg::REG_STEP_ANGLE, 24'hFF_FFFF);
    queue_step(1'b1, 1'b0);
    queue_step(1'b0, 1'b1);
    queue_step(1'b1, 1'b1);
    drain_pipeline();

    // random, turning mostly one way so the heading sweeps every quadrant
    write_reg(ddso_pkg::REG_STEP_DISTANCE, 24'($urandom_range(24'hFF_FFFF)));
    write_reg(ddso_pkg::REG_STEP_ANGLE, 24'hFF_FFFF);
    queue_random(370, 1, 1, 6, 2);
    drain_pipeline();

    send_idle_pct = 84;
    recv_idle_pct = 27;
    write_reg(ddso_pkg::REG_STEP_DISTANCE, 24'hFF_FFFF);
    write_reg(ddso_pkg::REG_STEP_ANGLE, 24'($urandom_range(24'hFF_FFFF, 24'h80_0000)));
    queue_random(370, 1, 6, 1, 2);
    drain_pipeline();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(ddso_pkg::REG_STEP_DISTANCE, 24'($urandom_range(24'hFF_FFFF)));
    write_reg(ddso_pkg::REG_STEP_ANGLE, 24'($urandom_range(24'hFF_FFFF)));
    queue_random(180, 1, 1, 1, 1);
    drain_pipeline();
    write_reg(ddso_pkg::REG_STEP_DISTANCE, 24'($urandom_range(24'hFF_FFFF)));
    write_reg(ddso_pkg::REG_STEP_ANGLE, 24'($urandom_range(24'hFF_FFFF)));
    queue_random(180, 1, 1, 1, 1);
    drain_pipeline();

    // let any stray result show up
    repeat (CORDIC_ITER + 10) @(posedge clk);

    $display("Checked %0d poses (%0d with wheel motion) from %0d items, %0d register writes,",
             poses_checked, moves_checked, items_sent, reg_writes);
    $display("under sender-heavy, receiver-heavy and back-to-back traffic.");
    if (mismatch_count == 0) begin
      $display("differential_drive_step_odometry regression: pass");
    end else begin
      $display("differential_drive_step_odometry regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("Timeout with %0d items pending, %0d results outstanding",
             pending_steps.size(), expected_poses.size());
    $display("differential_drive_step_odometry regression: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ddso_pkg.sv
hw/rtl/ddso_ctrl.sv
hw/rtl/ddso_dp.sv
hw/rtl/differential_drive_step_odometry.sv
sim/tb_differential_drive_step_odometry.sv
